FILE: hdl/access_token_table_assert.svh
// Assertion macros for the access token table.
`ifndef ACCESS_TOKEN_TABLE_ASSERT_SVH
`define ACCESS_TOKEN_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ATT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m fail");
`define ATT_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("%m fail");
`else
`define ATT_ASSERT(label, clk, rst_n, prop)
`define ATT_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: hdl/att_pkg.sv
// Shared types and constants of the access token table.
package att_pkg;
	localparam int TABLE_ENTRIES = 256;
	localparam int SLOT_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = SLOT_W + 1;
	localparam int HASH_SHIFT = 33;

	localparam logic [1:0] ACT_GEN = 2'd0;
	localparam logic [1:0] ACT_FIND = 2'd1;
	localparam logic [1:0] ACT_BURN = 2'd2;
	localparam logic [1:0] ACT_PURGE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_MASK = 2'd1;
	localparam logic [1:0] REG_LIFE = 2'd2;
	localparam logic [1:0] REG_BUCKETS = 2'd3;

	typedef struct packed {
		logic [31:0] ip;
		logic [1:0] kind;
		logic [62:0] nonce;
		logic [63:0] expiry;
		logic [15:0] bucket;
		logic [31:0] age;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_GSCAN, S_GRD, S_GWR, S_FRD, S_FCHK, S_BURN,
		S_PRD, S_PCHK, S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [63:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [15:0] rem;
	} div_rsp_t;
endpackage

FILE: hdl/att_mod_unit.sv
// Bit-serial remainder unit for the bucket hash.
module att_mod_unit (
	input  logic clk,
	input  logic arst_n,
	input  att_pkg::div_req_t req,
	output att_pkg::div_rsp_t rsp
);
	logic [63:0] dvd_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [6:0] cnt_q;
	logic busy_q, done_q;
	logic [16:0] sh;

	assign sh = {rem_q[15:0], dvd_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= (req.divisor == 16'd0) ? 16'd1 : req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= (sh >= {1'b0, dvs_q}) ? sh - {1'b0, dvs_q} : sh;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem = rem_q[15:0];
endmodule

FILE: hdl/att_store.sv
// Entry memory with registered read.
module att_store (
	input  logic clk,
	input  logic we,
	input  logic [att_pkg::SLOT_W-1:0] waddr,
	input  att_pkg::entry_t wdata,
	input  logic [att_pkg::SLOT_W-1:0] raddr,
	output att_pkg::entry_t rdata
);
	att_pkg::entry_t mem [att_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/access_token_table.sv
// Access token table top level.
// Items are handled one at a time. Generate takes, per requested type, a
// serial remainder for the bucket plus a scan of the valid bits for the
// lowest free slot; the scan holds at its slot while the previous transfer
// still waits in the output register. Find takes the same remainder and
// then reads the entry memory once per slot; purge takes the same pass
// without the remainder. Results leave through an output register;
// configuration writes are taken at any time and must be made only
// while idle.
module access_token_table (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [39:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] action,
	input  logic [31:0] ip,
	input  logic [1:0] token_type,
	input  logic [2:0] type_set,
	input  logic [62:0] query_nonce,
	input  logic [62:0] nonce_stats,
	input  logic [62:0] nonce_adder,
	input  logic [62:0] nonce_gauge,
	input  logic [7:0] slot,
	input  logic [62:0] now,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic [7:0] result_slot,
	output logic [1:0] result_type,
	output logic [62:0] result_nonce,
	output logic [8:0] purged_count,
	output logic last
);
`include "access_token_table_assert.svh"
	localparam int SW = att_pkg::SLOT_W;
	localparam int CW = att_pkg::CNT_W;

	logic enable_q;
	logic [2:0] mask_q;
	logic [39:0] life_q;
	logic [15:0] buckets_q;

	logic [att_pkg::TABLE_ENTRIES-1:0] valid_q, burned_q;
	logic [31:0] ins_q;

	att_pkg::state_t state_q, state_d;
	logic [1:0] act_q;
	logic [31:0] ip_q;
	logic [2:0] want_q;
	logic [62:0] qn_q, now_q;
	logic [62:0] n0_q, n1_q, n2_q;
	logic [7:0] slot_q;
	logic [1:0] kind_q;
	logic [15:0] hash_q;
	logic [CW-1:0] idx_q;
	logic found_q;
	logic [SW-1:0] best_q;
	logic [31:0] bestd_q;
	logic [1:0] bestk_q;
	logic [62:0] bestn_q;
	logic [CW-1:0] cnt_q;
	logic hash_go_q;

	logic ov_q;
	logic [1:0] st_q, rt_q;
	logic [7:0] rs_q;
	logic [62:0] rn_q;
	logic [8:0] pc_q;
	logic last_q;

	att_pkg::div_req_t dreq;
	att_pkg::div_rsp_t drsp;
	att_pkg::entry_t wdata, rdata;
	logic we;
	logic [SW-1:0] waddr, raddr;

	att_mod_unit u_mod (.clk, .arst_n, .req(dreq), .rsp(drsp));
	att_store u_store (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != att_pkg::S_IDLE) || ov_q;

	logic [62:0] cur_nonce;
	logic [2:0] want_left;
	logic [1:0] next_kind;
	logic more;
	always_comb begin
		case (kind_q)
			2'd0: cur_nonce = n0_q;
			2'd1: cur_nonce = n1_q;
			default: cur_nonce = n2_q;
		endcase
		if (cur_nonce == 63'd0) cur_nonce = now_q;
		want_left = want_q & ~(3'b001 << kind_q);
		next_kind = want_left[0] ? 2'd0 : (want_left[1] ? 2'd1 : 2'd2);
		more = want_left != 3'b000;
	end

	logic [SW-1:0] idx;
	assign idx = idx_q[SW-1:0];
	logic at_end;
	assign at_end = idx_q == CW'(att_pkg::TABLE_ENTRIES - 1);

	logic slot_ok;
	assign slot_ok = ({1'b0, slot_q} < CW'(att_pkg::TABLE_ENTRIES)) && valid_q[slot_q[SW-1:0]];

	logic match;
	logic [31:0] age_gap;
	assign age_gap = ins_q - rdata.age;
	assign match = valid_q[idx] && !burned_q[idx] && rdata.bucket == hash_q
		&& rdata.ip == ip_q && rdata.nonce == qn_q;
	logic expired;
	assign expired = {1'b0, now_q} >= rdata.expiry;

	always_comb begin
		dreq.start = hash_go_q;
		dreq.dividend = (64'd1 << (att_pkg::HASH_SHIFT + 32'(kind_q))) + {32'd0, ip_q};
		dreq.divisor = buckets_q;
		raddr = idx;
		we = (state_q == att_pkg::S_GWR);
		waddr = idx;
		wdata.ip = ip_q;
		wdata.kind = kind_q;
		wdata.nonce = cur_nonce;
		wdata.expiry = {1'b0, now_q} + {24'd0, life_q};
		wdata.bucket = hash_q;
		wdata.age = ins_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			att_pkg::S_IDLE: if (in_valid && !in_stall) begin
				case (action)
					att_pkg::ACT_GEN: state_d = (!enable_q || (type_set & mask_q) == 3'd0)
						? att_pkg::S_OUT : att_pkg::S_HASH;
					att_pkg::ACT_FIND: state_d = (query_nonce == 63'd0 || token_type == 2'd3)
						? att_pkg::S_OUT : att_pkg::S_HASH;
					att_pkg::ACT_BURN: state_d = att_pkg::S_BURN;
					default: state_d = att_pkg::S_PRD;
				endcase
			end
			att_pkg::S_HASH: if (drsp.done)
				state_d = (act_q == att_pkg::ACT_GEN) ? att_pkg::S_GSCAN : att_pkg::S_FRD;
			att_pkg::S_GSCAN: if (!ov_q) begin
				if (!valid_q[idx]) state_d = att_pkg::S_GWR;
				else if (at_end) state_d = att_pkg::S_GRD;
			end
			att_pkg::S_GWR, att_pkg::S_GRD: state_d = att_pkg::S_OUT;
			att_pkg::S_FRD: state_d = att_pkg::S_FCHK;
			att_pkg::S_FCHK: state_d = at_end ? att_pkg::S_OUT : att_pkg::S_FRD;
			att_pkg::S_BURN: state_d = att_pkg::S_OUT;
			att_pkg::S_PRD: state_d = att_pkg::S_PCHK;
			att_pkg::S_PCHK: state_d = at_end ? att_pkg::S_OUT : att_pkg::S_PRD;
			att_pkg::S_OUT: if (!ov_q)
				state_d = (act_q == att_pkg::ACT_GEN && st_q != att_pkg::ST_NONE && more)
					? att_pkg::S_HASH : att_pkg::S_IDLE;
			default: state_d = att_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mask_q <= 3'd7;
			life_q <= 40'd2000000000;
			buckets_q <= 16'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				att_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				att_pkg::REG_MASK: mask_q <= cfg_data[2:0];
				att_pkg::REG_LIFE: life_q <= cfg_data;
				att_pkg::REG_BUCKETS: buckets_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= att_pkg::S_IDLE;
			valid_q <= '0;
			burned_q <= '0;
			ins_q <= '0;
			ov_q <= 1'b0;
			hash_go_q <= 1'b0;
		end else begin
			state_q <= state_d;
			hash_go_q <= 1'b0;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (state_q)
				att_pkg::S_IDLE: if (in_valid && !in_stall) begin
					if (state_d == att_pkg::S_HASH) hash_go_q <= 1'b1;
				end
				att_pkg::S_GWR: begin
					valid_q[idx] <= 1'b1;
					burned_q[idx] <= 1'b0;
					ins_q <= ins_q + 32'd1;
				end
				att_pkg::S_BURN: if (slot_ok) burned_q[slot_q[SW-1:0]] <= 1'b1;
				att_pkg::S_PCHK: if (valid_q[idx] && (burned_q[idx] || expired)) begin
					valid_q[idx] <= 1'b0;
					burned_q[idx] <= 1'b0;
				end
				att_pkg::S_OUT: if (!ov_q) begin
					ov_q <= 1'b1;
					if (state_d == att_pkg::S_HASH) hash_go_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			att_pkg::S_IDLE: if (in_valid && !in_stall) begin
				act_q <= action;
				ip_q <= ip;
				want_q <= type_set & mask_q;
				qn_q <= query_nonce;
				now_q <= now;
				n0_q <= nonce_stats;
				n1_q <= nonce_adder;
				n2_q <= nonce_gauge;
				slot_q <= slot;
				idx_q <= '0;
				found_q <= 1'b0;
				cnt_q <= '0;
				if (action == att_pkg::ACT_GEN) begin
					logic [2:0] w;
					w = type_set & mask_q;
					kind_q <= w[0] ? 2'd0 : (w[1] ? 2'd1 : 2'd2);
				end else kind_q <= token_type;
			end
			att_pkg::S_HASH: begin
				idx_q <= '0;
				if (drsp.done) hash_q <= drsp.rem;
			end
			att_pkg::S_GSCAN: if (valid_q[idx] && !at_end) idx_q <= idx_q + CW'(1);
			att_pkg::S_FCHK, att_pkg::S_PCHK: begin
				idx_q <= idx_q + CW'(1);
				if (state_q == att_pkg::S_FCHK && match && (!found_q || age_gap < bestd_q)) begin
					found_q <= 1'b1;
					best_q <= idx;
					bestd_q <= age_gap;
					bestk_q <= rdata.kind;
					bestn_q <= rdata.nonce;
				end
				if (state_q == att_pkg::S_PCHK && valid_q[idx] && (burned_q[idx] || expired))
					cnt_q <= cnt_q + CW'(1);
			end
			att_pkg::S_OUT: if (!ov_q) begin
				kind_q <= next_kind;
				want_q <= want_left;
			end
			default: ;
		endcase

		case (state_q)
			att_pkg::S_IDLE: if (in_valid && !in_stall) begin
				st_q <= (action == att_pkg::ACT_GEN) ? att_pkg::ST_NONE : att_pkg::ST_NOTFOUND;
				rs_q <= '0; rt_q <= '0; rn_q <= '0; pc_q <= '0; last_q <= 1'b1;
			end
			att_pkg::S_GWR: begin
				st_q <= att_pkg::ST_OK; rs_q <= 8'(idx); rt_q <= kind_q;
				rn_q <= cur_nonce; pc_q <= '0; last_q <= !more;
			end
			att_pkg::S_GRD: begin
				st_q <= att_pkg::ST_FULL; rs_q <= '0; rt_q <= '0;
				rn_q <= '0; pc_q <= '0; last_q <= !more;
			end
			att_pkg::S_FCHK: if (at_end) begin
				if (found_q || (match && 1'b1)) begin
					st_q <= att_pkg::ST_OK;
					if (match && (!found_q || age_gap < bestd_q)) begin
						rs_q <= 8'(idx); rt_q <= rdata.kind; rn_q <= rdata.nonce;
					end else begin
						rs_q <= 8'(best_q); rt_q <= bestk_q; rn_q <= bestn_q;
					end
				end
			end
			att_pkg::S_BURN: if (slot_ok) begin
				st_q <= att_pkg::ST_OK; rs_q <= slot_q;
			end
			att_pkg::S_PCHK: if (at_end) begin
				st_q <= att_pkg::ST_OK;
				pc_q <= 9'((valid_q[idx] && (burned_q[idx] || expired)) ? cnt_q + CW'(1) : cnt_q);
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign status = st_q;
	assign result_slot = rs_q;
	assign result_type = rt_q;
	assign result_nonce = rn_q;
	assign purged_count = pc_q;
	assign last = last_q;

	`ATT_ASSERT(a_no_accept_busy, clk, arst_n, (in_valid && !in_stall) |-> (state_q == att_pkg::S_IDLE))
	`ATT_ASSERT(a_out_hold, clk, arst_n, (ov_q && out_stall) |=> (ov_q && $stable(st_q)))
	`ATT_ASSERT(a_write_idle_slot, clk, arst_n, we |-> !valid_q[waddr])
	`ATT_ASSERT_RST(a_reset_idle, clk, !arst_n |=> (state_q == att_pkg::S_IDLE))
endmodule
